>>> src/mlp_pkg.sv
`timescale 1ns / 1ps

package mlp_pkg;

  // Sizing of the network.
  localparam int MAX_INPUTS      = 16;
  localparam int MAX_NEURONS     = 16;
  localparam int ACT_TABLE_DEPTH = 256;

  // Inputs and neurons are addressed with a fixed stride of 16.
  localparam int LANE_CAP = 16;
  localparam int LANE_W   = $clog2(LANE_CAP);
  localparam int CNT_W    = 5;
  localparam int LANES_IN = (MAX_INPUTS < LANE_CAP) ? MAX_INPUTS : LANE_CAP;
  localparam int LANES_N  = (MAX_NEURONS < LANE_CAP) ? MAX_NEURONS : LANE_CAP;

  localparam int NUM_LAYERS = 3;
  localparam int LAYER_W    = 2;

  // Weight memory holds the weights of all layers, then the biases.
  localparam int WEIGHTS_PER_LAYER = LANE_CAP * LANE_CAP;
  localparam int BIAS_BASE  = NUM_LAYERS * WEIGHTS_PER_LAYER;
  localparam int WMEM_DEPTH = BIAS_BASE + NUM_LAYERS * LANE_CAP;
  localparam int WMEM_AW    = $clog2(WMEM_DEPTH);

  // Activation memory: input vector, ping and pong banks.
  localparam int NUM_BANKS  = 3;
  localparam int AMEM_DEPTH = NUM_BANKS * LANE_CAP;
  localparam int AMEM_AW    = LAYER_W + LANE_W;
  localparam logic [LAYER_W-1:0] BANK_IN   = 2'd0;
  localparam logic [LAYER_W-1:0] BANK_PING = 2'd1;
  localparam logic [LAYER_W-1:0] BANK_PONG = 2'd2;

  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int FRAC_W = 16;
  localparam int ACC_W  = 52;

  localparam logic signed [DATA_W-1:0] Q_ONE       = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] Q_MINUS_ONE = 32'shFFFF_0000;
  localparam logic signed [DATA_W-1:0] Q_ZERO      = 32'sh0000_0000;

  // Activation table lookup over [-8, 8).
  localparam int TAB_AW    = $clog2(ACT_TABLE_DEPTH);
  localparam int TAB_SHIFT = 20 - TAB_AW;
  localparam int TAB_TOP   = TAB_SHIFT + TAB_AW;
  localparam logic signed [DATA_W:0] TAB_OFFSET = 33'sd524288;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_NEURONS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_NEURONS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_L3_NEURONS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_L1_TRANSFER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_L2_TRANSFER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_L3_TRANSFER = 3'd6;

  // Transfer codes; codes above hardlims act as linear.
  localparam int XF_W = 3;
  localparam logic [XF_W-1:0] XF_LOGSIG   = 3'd0;
  localparam logic [XF_W-1:0] XF_TANSIG   = 3'd1;
  localparam logic [XF_W-1:0] XF_LINEAR   = 3'd2;
  localparam logic [XF_W-1:0] XF_HARDLIM  = 3'd3;
  localparam logic [XF_W-1:0] XF_HARDLIMS = 3'd4;

  // Request kinds.
  localparam logic [1:0] REQ_WEIGHT = 2'd0;
  localparam logic [1:0] REQ_BIAS   = 2'd1;
  localparam logic [1:0] REQ_ELEM   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAYER,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD
  } mlp_state_t;

  typedef logic signed [DATA_W-1:0] act_tab_t [ACT_TABLE_DEPTH];

  localparam longint unsigned Q31 = 64'd2147483648;

  // Unsigned 64-bit quotient by shift and subtract; used only while the tables are built.
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-t with t and result in Q31: Taylor series of e^-(t/32), then squared five times.
  function automatic longint unsigned exp_neg_q31(input longint unsigned t);
    longint unsigned g;
    longint unsigned term;
    longint unsigned s;
    longint          sum;
    g    = t >> 5;
    sum  = longint'(Q31);
    term = Q31;
    for (int k = 1; k <= 12; k++) begin
      term = udiv((term * g) >> 31, 64'(k));
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    s = longint'(sum);
    for (int k = 0; k < 5; k++) begin
      s = (s * s + 64'd1073741824) >> 31;
    end
    return s;
  endfunction

  // Both tables hold the function at the bin midpoints, rounded to Q16.16.
  function automatic act_tab_t build_logsig();
    act_tab_t        tab;
    longint          num;
    longint unsigned a;
    longint unsigned e;
    longint unsigned den;
    longint unsigned v;
    for (int i = 0; i < ACT_TABLE_DEPTH; i++) begin
      num = 16 * (2 * longint'(i) + 1) - 16 * ACT_TABLE_DEPTH;
      a   = (num < 0) ? longint'(-num) : longint'(num);
      e   = exp_neg_q31((a << 31) / (2 * ACT_TABLE_DEPTH));
      den = Q31 + e;
      if (num < 0) begin
        v = udiv((e << 16) + den / 2, den);
      end else begin
        v = udiv((64'd1 << 47) + den / 2, den);
      end
      tab[i] = v[DATA_W-1:0];
    end
    return tab;
  endfunction

  function automatic act_tab_t build_tansig();
    act_tab_t        tab;
    longint          num;
    longint unsigned a;
    longint unsigned e;
    longint unsigned den;
    longint unsigned v;
    for (int i = 0; i < ACT_TABLE_DEPTH; i++) begin
      num = 16 * (2 * longint'(i) + 1) - 16 * ACT_TABLE_DEPTH;
      a   = (num < 0) ? longint'(-num) : longint'(num);
      e   = exp_neg_q31((a << 31) / ACT_TABLE_DEPTH);
      den = Q31 + e;
      v   = udiv(((Q31 - e) << 16) + den / 2, den);
      tab[i] = (num < 0) ? -v[DATA_W-1:0] : v[DATA_W-1:0];
    end
    return tab;
  endfunction

  localparam act_tab_t LOGSIG_TAB = build_logsig();
  localparam act_tab_t TANSIG_TAB = build_tansig();

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] cap);
    return (v > cap) ? cap : v;
  endfunction

endpackage

>>> src/mlp_if.sv
`timescale 1ns / 1ps

interface mlp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [1:0]         layer_select;
  logic [7:0]         entry_index;
  logic signed [31:0] value;
  logic               last_element;

  modport source (output valid, req_type, layer_select, entry_index, value, last_element,
                  input ready);
  modport sink (input valid, req_type, layer_select, entry_index, value, last_element,
                output ready);
endinterface

interface mlp_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         class_index;
  logic signed [31:0] score;
  logic               last_class;

  modport source (output valid, class_index, score, last_class, input ready);
  modport sink (input valid, class_index, score, last_class, output ready);
endinterface

>>> src/mlp_classifier_inference_unit.sv
`timescale 1ns / 1ps

// Feedforward classifier with up to three layers, Q16.16 arithmetic.
// Input channel in_ch: each beat is a weight write, a bias write or one element
// of the input vector. An element beat with last_element set starts an evaluation.
// Output channel out_ch: one beat per neuron of the final layer, in neuron order,
// last_class set on the final one. Configuration goes through cfg_we, cfg_index,
// cfg_data; the user must write it only while the block is idle, which the block
// itself does not enforce. Load beats are taken back to back. An evaluation runs
// one shared multiply-accumulate fed by the weight memory and the activation
// memory, one product or bias per cycle: each layer has a setup state, a product
// per input and a bias per neuron, and a drain until the pipeline is empty before
// the next layer may read what it wrote. Each score is then read from the
// registered activation memory in one state and loaded into the output register
// in another, so score beats never leave back to back. in_ch.ready is high only
// while no evaluation runs. A stalled receiver holds the output register and the
// evaluation waits on it; the next load beats are still taken while the final
// score waits. Reset sets the counts to one input and one layer-1 neuron, all
// transfer codes to logsig, and empties the pipeline; the memories are not cleared.
module mlp_classifier_inference_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  mlp_in_if.sink                          in_ch,
  mlp_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [mlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mlp_pkg::*;

  // Configuration registers.
  logic [CNT_W-1:0] in_count_r, l1_n_r, l2_n_r, l3_n_r;
  logic [XF_W-1:0]  xf1_r, xf2_r, xf3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_count_r <= CNT_W'(1);
      l1_n_r     <= CNT_W'(1);
      l2_n_r     <= '0;
      l3_n_r     <= '0;
      xf1_r      <= XF_LOGSIG;
      xf2_r      <= XF_LOGSIG;
      xf3_r      <= XF_LOGSIG;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INPUT_COUNT: in_count_r <= cfg_data;
        CFG_L1_NEURONS:  l1_n_r     <= cfg_data;
        CFG_L2_NEURONS:  l2_n_r     <= cfg_data;
        CFG_L3_NEURONS:  l3_n_r     <= cfg_data;
        CFG_L1_TRANSFER: xf1_r      <= cfg_data[XF_W-1:0];
        CFG_L2_TRANSFER: xf2_r      <= cfg_data[XF_W-1:0];
        CFG_L3_TRANSFER: xf3_r      <= cfg_data[XF_W-1:0];
        default: ;
      endcase
    end
  end

  // Counts above the lane capacity saturate.
  logic [CNT_W-1:0] n0, n1, n2, n3;
  assign n0 = clamp_cnt(in_count_r, CNT_W'(LANES_IN));
  assign n1 = clamp_cnt(l1_n_r, CNT_W'(LANES_N));
  assign n2 = clamp_cnt(l2_n_r, CNT_W'(LANES_N));
  assign n3 = clamp_cnt(l3_n_r, CNT_W'(LANES_N));

  // Sequencer state.
  mlp_state_t         state_r, state_nxt;
  logic [LAYER_W-1:0] layer_r, layer_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;

  // Per-layer selections: layer 1 reads the input bank and writes ping, layer 2
  // reads ping and writes pong, layer 3 reads pong and writes ping.
  logic [CNT_W-1:0]   nin, nout;
  logic [XF_W-1:0]    code;
  logic [LAYER_W-1:0] src_bank, dst_bank;

  always_comb begin
    unique case (layer_r)
      2'd0: begin
        nin = n0; nout = n1; code = xf1_r; src_bank = BANK_IN; dst_bank = BANK_PING;
      end
      2'd1: begin
        nin = n1; nout = n2; code = xf2_r; src_bank = BANK_PING; dst_bank = BANK_PONG;
      end
      default: begin
        nin = n2; nout = n3; code = xf3_r; src_bank = BANK_PONG; dst_bank = BANK_PING;
      end
    endcase
  end

  // Input beats.
  logic in_acc, start;
  logic bias_ok, elem_ok, layer_ok;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign layer_ok    = in_ch.layer_select < LAYER_W'(NUM_LAYERS);
  assign bias_ok     = in_ch.entry_index[7:LANE_W] == '0;
  assign elem_ok     = in_ch.entry_index[7:LANE_W] == '0;
  assign start       = in_acc && (in_ch.req_type == REQ_ELEM) && in_ch.last_element;

  // Pipeline valid bits and output register.
  logic s1_v_r, s2_v_r, s3_v_r;
  logic pipe_empty;
  logic out_valid_r;
  assign pipe_empty = !s1_v_r && !s2_v_r && !s3_v_r;

  logic issue_prod, issue_bias, emit_re, out_load, adv_layer;
  assign adv_layer = pipe_empty &&
                     (((layer_r == 2'd0) && (n2 != '0)) || ((layer_r == 2'd1) && (n3 != '0)));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (start) state_nxt = ST_LAYER;
      ST_LAYER:   state_nxt = (nout == '0) ? ST_DRAIN : ST_MAC;
      ST_MAC:     if ((k_r >= nin) && (n_r + CNT_W'(1) == nout)) state_nxt = ST_DRAIN;
      ST_DRAIN:   if (pipe_empty) state_nxt = adv_layer ? ST_LAYER : ST_EMIT_RD;
      ST_EMIT_RD: state_nxt = (k_r == nout) ? ST_IDLE : ST_EMIT_LD;
      ST_EMIT_LD: if (out_load) state_nxt = ST_EMIT_RD;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs and counters.
  always_comb begin
    issue_prod = 1'b0;
    issue_bias = 1'b0;
    emit_re    = 1'b0;
    out_load   = 1'b0;
    layer_nxt  = layer_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          layer_nxt = '0;
        end
      end
      ST_LAYER: begin
        n_nxt = '0;
        k_nxt = '0;
      end
      ST_MAC: begin
        if (k_r < nin) begin
          issue_prod = 1'b1;
          k_nxt      = k_r + CNT_W'(1);
        end else begin
          issue_bias = 1'b1;
          k_nxt      = '0;
          n_nxt      = n_r + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        k_nxt = '0;
        if (adv_layer) begin
          layer_nxt = layer_r + LAYER_W'(1);
        end
      end
      ST_EMIT_RD: begin
        emit_re = (k_r != nout);
      end
      ST_EMIT_LD: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load = 1'b1;
          k_nxt    = k_r + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      layer_r <= '0;
      n_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      layer_r <= layer_nxt;
      n_r     <= n_nxt;
      k_r     <= k_nxt;
    end
  end

  // Weight memory: weights of the three layers followed by their biases.
  logic signed [DATA_W-1:0] wmem [WMEM_DEPTH];
  logic                     w_we, w_re;
  logic [WMEM_AW-1:0]       w_waddr, w_raddr;
  logic signed [DATA_W-1:0] w_q_r;

  assign w_we = in_acc && layer_ok &&
                ((in_ch.req_type == REQ_WEIGHT) || ((in_ch.req_type == REQ_BIAS) && bias_ok));
  assign w_waddr = (in_ch.req_type == REQ_WEIGHT) ?
                   WMEM_AW'({in_ch.layer_select, in_ch.entry_index}) :
                   WMEM_AW'(BIAS_BASE) +
                   WMEM_AW'({in_ch.layer_select, in_ch.entry_index[LANE_W-1:0]});
  assign w_re    = issue_prod || issue_bias;
  assign w_raddr = issue_bias ?
                   WMEM_AW'(BIAS_BASE) + WMEM_AW'({layer_r, n_r[LANE_W-1:0]}) :
                   WMEM_AW'({layer_r, n_r[LANE_W-1:0], k_r[LANE_W-1:0]});

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= in_ch.value;
    end
    if (w_re) begin
      w_q_r <= wmem[w_raddr];
    end
  end

  // Activation memory: input vector and the two layer-output banks.
  logic signed [DATA_W-1:0] amem [AMEM_DEPTH];
  logic                     a_we, a_re;
  logic [AMEM_AW-1:0]       a_waddr, a_raddr;
  logic signed [DATA_W-1:0] a_wdata;
  logic signed [DATA_W-1:0] a_q_r;
  logic signed [DATA_W-1:0] xf_out;
  logic [LANE_W-1:0]        s3_n_r;

  assign a_we    = s3_v_r || (in_acc && (in_ch.req_type == REQ_ELEM) && elem_ok);
  assign a_waddr = s3_v_r ? {dst_bank, s3_n_r} : {BANK_IN, in_ch.entry_index[LANE_W-1:0]};
  assign a_wdata = s3_v_r ? xf_out : in_ch.value;
  assign a_re    = issue_prod || emit_re;
  assign a_raddr = emit_re ? {dst_bank, k_r[LANE_W-1:0]} : {src_bank, k_r[LANE_W-1:0]};

  always_ff @(posedge clk) begin
    if (a_we) begin
      amem[a_waddr] <= a_wdata;
    end
    if (a_re) begin
      a_q_r <= amem[a_raddr];
    end
  end

  // MAC pipeline: memory data, product, accumulate, then transfer and write back.
  // A bias travels the product path scaled by 1.0, so the floor leaves it exact.
  logic                     s1_bias_r, s2_bias_r;
  logic [LANE_W-1:0]        s1_n_r, s2_n_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_sum;
  logic signed [DATA_W-1:0] sat_r, sat_val;

  // The upper bits of the product are its floor in Q16.16; they keep their sign.
  assign acc_sum = acc_r + ACC_W'(signed'(prod_r[PROD_W-1:FRAC_W]));

  always_comb begin
    if ((acc_sum[ACC_W-1:DATA_W-1] == '0) || (acc_sum[ACC_W-1:DATA_W-1] == '1)) begin
      sat_val = acc_sum[DATA_W-1:0];
    end else if (acc_sum[ACC_W-1]) begin
      sat_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      acc_r  <= '0;
    end else begin
      s1_v_r <= w_re;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r && s2_bias_r;
      if (s2_v_r) begin
        acc_r <= s2_bias_r ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_bias_r <= issue_bias;
    s1_n_r    <= n_r[LANE_W-1:0];
    s2_bias_r <= s1_bias_r;
    s2_n_r    <= s1_n_r;
    if (s1_bias_r) begin
      prod_r <= {{FRAC_W{w_q_r[DATA_W-1]}}, w_q_r, {FRAC_W{1'b0}}};
    end else begin
      prod_r <= w_q_r * a_q_r;
    end
    s3_n_r <= s2_n_r;
    sat_r  <= sat_val;
  end

  // Transfer function; the table index clamps below -8 and at or above +8.
  logic signed [DATA_W:0] tix_sum;
  logic [TAB_AW-1:0]      tix;

  assign tix_sum = {sat_r[DATA_W-1], sat_r} + TAB_OFFSET;

  always_comb begin
    if (tix_sum[DATA_W]) begin
      tix = '0;
    end else if (tix_sum[DATA_W-1:TAB_TOP] != '0) begin
      tix = '1;
    end else begin
      tix = tix_sum[TAB_TOP-1:TAB_SHIFT];
    end
  end

  always_comb begin
    unique case (code)
      XF_LOGSIG:   xf_out = LOGSIG_TAB[tix];
      XF_TANSIG:   xf_out = TANSIG_TAB[tix];
      XF_LINEAR:   xf_out = sat_r;
      XF_HARDLIM:  xf_out = sat_r[DATA_W-1] ? Q_ZERO : Q_ONE;
      XF_HARDLIMS: xf_out = sat_r[DATA_W-1] ? Q_MINUS_ONE : Q_ONE;
      default:     xf_out = sat_r;
    endcase
  end

  // Output register.
  logic [LANE_W-1:0]        out_idx_r;
  logic signed [DATA_W-1:0] out_score_r;
  logic                     out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r   <= k_r[LANE_W-1:0];
      out_score_r <= a_q_r;
      out_last_r  <= (k_r + CNT_W'(1) == nout);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.class_index = out_idx_r;
  assign out_ch.score       = out_score_r;
  assign out_ch.last_class  = out_last_r;

  // The pipeline is empty whenever input beats can be taken.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> pipe_empty)
    else $error("MAC pipeline busy while idle");

  // Write-back never competes with an input element write.
  a_wb_busy: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> (state_r == ST_MAC || state_r == ST_DRAIN))
    else $error("write-back outside a layer pass");

  // Results are read only after all layer writes have landed.
  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_RD || state_r == ST_EMIT_LD) |-> pipe_empty)
    else $error("emit while pipeline busy");

  // A score is loaded only for a neuron that exists.
  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (k_r < nout))
    else $error("score index beyond neuron count");

endmodule

>>> bench/mlp_classifier_inference_unit_tb.sv
`timescale 1ns / 1ps

// Bench for the three-layer classifier. An in-bench predictor keeps its own
// copy of the weight, bias and sample memories plus the configuration. Every
// accepted beat the block keeps updates that copy, and an element beat marked last
// queues the scores the final layer should emit. A checker process pops one
// expectation per accepted output beat and compares it field by field.
module mlp_classifier_inference_unit_tb;
  import mlp_pkg::*;

  localparam longint     CYCLE_LIMIT   = 2_000_000;
  localparam int         SETTLE_CYCLES = 24;
  localparam int         RANDOM_BEATS  = 500;
  localparam logic [1:0] REQ_UNUSED    = 2'd3;
  localparam logic [1:0] LAYER_UNUSED  = 2'd3;
  localparam logic [2:0] XF_UNKNOWN    = 3'd7;

  typedef logic signed [31:0] q_t;
  typedef q_t vec_t [16];
  typedef struct {
    logic [3:0] cls;
    q_t         score;
    logic       last;
  } score_t;

  localparam q_t FIX_ONE   = 32'sh0001_0000;
  localparam q_t FIX_M_ONE = 32'shFFFF_0000;
  localparam q_t FIX_MAX   = 32'sh7FFF_FFFF;
  localparam q_t FIX_MIN   = 32'sh8000_0000;
  localparam longint unsigned ONE31 = 64'd2147483648;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mlp_in_if  in_bus ();
  mlp_out_if out_bus ();

  mlp_classifier_inference_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: the memories as the block should hold them, plus the
  // configuration registers at their reset values.
  q_t         weight_mem [768];
  q_t         bias_mem [48];
  vec_t       sample_vec;
  q_t         logsig_lut [256];
  q_t         tansig_lut [256];
  logic [4:0] cnt_in, cnt_l1, cnt_l2, cnt_l3;
  logic [2:0] xf_l1, xf_l2, xf_l3;

  score_t pending_scores [$];
  int     errors;
  longint cycles;
  int     beats_sent;
  int     evaluations;
  int     scores_seen;
  int     burst_left;
  int     stall_mode;
  int     stall_left;
  int     stall_tick;

  // Clock: 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // e^-t in Q31 for t in [0, 16] (Q31): a short Taylor series on t/32, then
  // squared five times to recover the full exponent.
  function automatic longint unsigned decay_q31(input longint unsigned t);
    longint unsigned step;
    longint unsigned term;
    longint unsigned sq;
    longint          acc;
    step = t >> 5;
    acc  = longint'(ONE31);
    term = ONE31;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * step) >> 31) / longint'(k);
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    sq = longint'(acc);
    for (int k = 0; k < 5; k++) begin
      sq = (sq * sq + 64'd1073741824) >> 31;
    end
    return sq;
  endfunction

  // Fill both sigmoid tables with the function value at each bin midpoint.
  task automatic build_luts();
    longint          num;
    longint unsigned mag;
    longint unsigned e;
    longint unsigned den;
    longint unsigned v;
    for (int i = 0; i < 256; i++) begin
      num = 16 * (2 * longint'(i) + 1) - 16 * 256;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      e   = decay_q31((mag << 31) / 512);
      den = ONE31 + e;
      if (num < 0) begin
        v = ((e << 16) + den / 2) / den;
      end else begin
        v = ((64'd1 << 47) + den / 2) / den;
      end
      logsig_lut[i] = v[31:0];
      e   = decay_q31((mag << 31) / 256);
      den = ONE31 + e;
      v   = (((ONE31 - e) << 16) + den / 2) / den;
      tansig_lut[i] = (num < 0) ? -q_t'(v[31:0]) : q_t'(v[31:0]);
    end
  endtask

  // Table index covers [-8, 8) in 256 bins; values outside clamp to the ends.
  function automatic q_t lut_pick(input bit use_tansig, input q_t v);
    longint n;
    if (v < -32'sd524288) begin
      n = 0;
    end else begin
      n = (longint'(v) + 524288) >>> 12;
      if (n > 255) begin
        n = 255;
      end
    end
    return use_tansig ? tansig_lut[n] : logsig_lut[n];
  endfunction

  function automatic q_t apply_transfer(input q_t v, input logic [2:0] code);
    case (code)
      XF_LOGSIG:   return lut_pick(1'b0, v);
      XF_TANSIG:   return lut_pick(1'b1, v);
      XF_HARDLIM:  return (v >= 0) ? FIX_ONE : 32'sd0;
      XF_HARDLIMS: return (v >= 0) ? FIX_ONE : FIX_M_ONE;
      default:     return v;  // Linear, and every unknown code.
    endcase
  endfunction

  function automatic int lanes(input logic [4:0] c);
    return (c > 5'd16) ? 16 : int'(c);
  endfunction

  // One layer: floored Q16.16 products summed exactly, bias added, saturated.
  function automatic vec_t layer_out(input int layer, input int nin, input int nout,
                                     input vec_t src, input logic [2:0] code);
    vec_t   dst;
    longint acc;
    dst = '{default: 32'sd0};
    for (int n = 0; n < nout; n++) begin
      acc = 0;
      for (int k = 0; k < nin; k++) begin
        acc += (longint'(weight_mem[layer * 256 + n * 16 + k]) * longint'(src[k])) >>> 16;
      end
      acc += longint'(bias_mem[layer * 16 + n]);
      if (acc > longint'(FIX_MAX)) begin
        acc = longint'(FIX_MAX);
      end else if (acc < longint'(FIX_MIN)) begin
        acc = longint'(FIX_MIN);
      end
      dst[n] = apply_transfer(q_t'(acc), code);
    end
    return dst;
  endfunction

  // Runs the network on the current sample and queues the final layer scores.
  task automatic predict_scores();
    vec_t   a;
    vec_t   b;
    vec_t   res;
    int     cnt;
    score_t s;
    a   = layer_out(0, lanes(cnt_in), lanes(cnt_l1), sample_vec, xf_l1);
    res = a;
    cnt = lanes(cnt_l1);
    if (lanes(cnt_l2) != 0) begin
      b   = layer_out(1, lanes(cnt_l1), lanes(cnt_l2), a, xf_l2);
      res = b;
      cnt = lanes(cnt_l2);
      if (lanes(cnt_l3) != 0) begin
        a   = layer_out(2, lanes(cnt_l2), lanes(cnt_l3), b, xf_l3);
        res = a;
        cnt = lanes(cnt_l3);
      end
    end
    for (int k = 0; k < cnt; k++) begin
      s.cls   = k[3:0];
      s.score = res[k];
      s.last  = (k + 1 == cnt);
      pending_scores.push_back(s);
    end
    evaluations++;
  endtask

  task automatic track_beat(input logic [1:0] req, input logic [1:0] layer,
                            input logic [7:0] idx, input q_t val, input logic last);
    case (req)
      REQ_WEIGHT: begin
        if (layer != LAYER_UNUSED) weight_mem[layer * 256 + idx] = val;
      end
      REQ_BIAS: begin
        if (layer != LAYER_UNUSED && idx < 16) bias_mem[layer * 16 + idx] = val;
      end
      REQ_ELEM: begin
        if (idx < 16) sample_vec[idx] = val;
        if (last) predict_scores();
      end
      default: ;  // Unused request kind: nothing happens.
    endcase
  endtask

  // Sends one beat. The sender works in bursts; between bursts valid drops for
  // a random gap, and some bursts follow on with no gap at all.
  task automatic send_beat(input logic [1:0] req, input logic [1:0] layer,
                           input logic [7:0] idx, input q_t val, input logic last);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    @(negedge clk);
    if (gap != 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.req_type     = req;
    in_bus.layer_select = layer;
    in_bus.entry_index  = idx;
    in_bus.value        = val;
    in_bus.last_element = last;
    in_bus.valid        = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    burst_left--;
    beats_sent++;
    track_beat(req, layer, idx, val, last);
  endtask

  // Holds the sender until every queued score has come back, then lets the
  // block settle so it is idle for a configuration write.
  task automatic hold_off();
    @(negedge clk);
    in_bus.valid = 1'b0;
    burst_left   = 0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [4:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    case (idx)
      CFG_INPUT_COUNT: cnt_in = data;
      CFG_L1_NEURONS:  cnt_l1 = data;
      CFG_L2_NEURONS:  cnt_l2 = data;
      CFG_L3_NEURONS:  cnt_l3 = data;
      CFG_L1_TRANSFER: xf_l1  = data[2:0];
      CFG_L2_TRANSFER: xf_l2  = data[2:0];
      CFG_L3_TRANSFER: xf_l3  = data[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_network(input logic [4:0] n_in, input logic [4:0] n1,
                             input logic [4:0] n2, input logic [4:0] n3,
                             input logic [2:0] x1, input logic [2:0] x2,
                             input logic [2:0] x3);
    hold_off();
    write_reg(CFG_INPUT_COUNT, n_in);
    write_reg(CFG_L1_NEURONS, n1);
    write_reg(CFG_L2_NEURONS, n2);
    write_reg(CFG_L3_NEURONS, n3);
    write_reg(CFG_L1_TRANSFER, {2'b00, x1});
    write_reg(CFG_L2_TRANSFER, {2'b00, x2});
    write_reg(CFG_L3_TRANSFER, {2'b00, x3});
  endtask

  // Mostly values within +-2.0 so deep networks stay out of saturation, with
  // some full-range words and the extremes mixed in.
  function automatic q_t rand_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return FIX_MAX;
          1:       return FIX_MIN;
          2:       return FIX_ONE;
          3:       return FIX_M_ONE;
          default: return 32'sd0;
        endcase
      end
      1, 2:    return q_t'($urandom);
      default: return q_t'($urandom_range(0, 262143)) - 32'sd131072;
    endcase
  endfunction

  // Feeds a full sample: elements 0..n-1, the last one starting evaluation.
  task automatic send_sample(input int n, input bit noisy);
    for (int k = 0; k < n; k++) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        send_beat(REQ_ELEM, 2'($urandom), 8'($urandom_range(16, 255)), rand_value(), 1'b0);
      end
      send_beat(REQ_ELEM, 2'($urandom), k[7:0], rand_value(), k == n - 1);
    end
  endtask

  // Every memory word the network can read gets written once up front, so no
  // evaluation ever reads an entry the block has never been given.
  task automatic test_preload();
    for (int i = 0; i < 768; i++) begin
      send_beat(REQ_WEIGHT, 2'(i / 256), 8'(i % 256),
                q_t'($urandom_range(0, 131071)) - 32'sd65536, 1'($urandom));
    end
    for (int i = 0; i < 48; i++) begin
      send_beat(REQ_BIAS, 2'(i / 16), 8'(i % 16),
                q_t'($urandom_range(0, 131071)) - 32'sd65536, 1'($urandom));
    end
    for (int i = 0; i < 16; i++) begin
      send_beat(REQ_ELEM, 2'($urandom), i[7:0], rand_value(), 1'b0);
    end
  endtask

  // Reset configuration: one input, one logsig neuron. The sample runs to both
  // ends of the range so the table clamps on each side.
  task automatic test_reset_defaults();
    send_beat(REQ_WEIGHT, 2'd0, 8'd0, FIX_ONE, 1'b0);
    send_beat(REQ_BIAS, 2'd0, 8'd0, 32'sd0, 1'b0);
    send_beat(REQ_ELEM, 2'd0, 8'd0, FIX_MAX, 1'b1);
    send_beat(REQ_ELEM, 2'd3, 8'd0, FIX_MIN, 1'b1);
    send_beat(REQ_ELEM, 2'd0, 8'd0, 32'sd0, 1'b1);
  endtask

  // Each transfer code, including unknown code 7, which acts as linear.
  task automatic test_transfer_codes();
    for (int c = 0; c <= 7; c++) begin
      if (c == 5 || c == 6) continue;
      set_network(5'd2, 5'd2, 5'd0, 5'd0, 3'(c), XF_LINEAR, XF_LINEAR);
      send_sample(2, 1'b0);
    end
  endtask

  // Largest network, then counts above the lane limit that must saturate.
  task automatic test_deep_network();
    set_network(5'd16, 5'd16, 5'd16, 5'd16, XF_TANSIG, XF_LOGSIG, XF_HARDLIMS);
    send_sample(16, 1'b0);
    set_network(5'd31, 5'd20, 5'd17, 5'd31, XF_LINEAR, XF_HARDLIM, XF_UNKNOWN);
    send_sample(16, 1'b0);
  endtask

  // Beats the block must drop, then an evaluation on an element it ignores.
  task automatic test_ignored_beats();
    set_network(5'd3, 5'd4, 5'd2, 5'd0, XF_LINEAR, XF_TANSIG, XF_LOGSIG);
    send_beat(REQ_UNUSED, 2'd0, 8'd0, FIX_MAX, 1'b1);
    send_beat(REQ_WEIGHT, LAYER_UNUSED, 8'd255, FIX_MIN, 1'b1);
    send_beat(REQ_BIAS, LAYER_UNUSED, 8'd3, FIX_MAX, 1'b0);
    send_beat(REQ_BIAS, 2'd1, 8'd200, FIX_MAX, 1'b0);
    send_beat(REQ_ELEM, 2'd0, 8'd99, FIX_MAX, 1'b1);
  endtask

  // Random phases: a random network, then several samples with weight and
  // bias reloads and some noise in between.
  task automatic test_random_traffic();
    int start;
    int runs;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      set_network($urandom_range(0, 5) == 0 ? 5'd16 : 5'($urandom_range(1, 6)),
                  $urandom_range(0, 5) == 0 ? 5'd16 : 5'($urandom_range(1, 6)),
                  $urandom_range(0, 2) == 0 ? 5'd0 : 5'($urandom_range(1, 8)),
                  $urandom_range(0, 2) == 0 ? 5'd0 : 5'($urandom_range(1, 8)),
                  3'($urandom_range(0, 4)), 3'($urandom_range(0, 4)),
                  $urandom_range(0, 9) == 0 ? XF_UNKNOWN : 3'($urandom_range(0, 4)));
      runs = $urandom_range(3, 8);
      repeat (runs) begin
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(0, 9))
            0:       send_beat(REQ_UNUSED, 2'($urandom), 8'($urandom), q_t'($urandom),
                               1'($urandom));
            1, 2, 3: send_beat(REQ_BIAS, 2'($urandom), 8'($urandom_range(0, 20)),
                               rand_value(), 1'($urandom));
            default: send_beat(REQ_WEIGHT, 2'($urandom), 8'($urandom), rand_value(),
                               1'($urandom));
          endcase
        end
        send_sample(lanes(cnt_in), 1'b1);
        if ($urandom_range(0, 5) == 0) hold_off();
      end
    end
  endtask

  // Receiver stalls follow their own pattern: always ready, random, or a
  // fixed duty cycle, each mode held for a random stretch.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready = 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        0:       out_bus.ready = 1'b1;
        1:       out_bus.ready = ($urandom_range(0, 2) != 0);
        default: out_bus.ready = (stall_tick % 5 < 2);
      endcase
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= 40) begin
      $display("MISMATCH %s: got %0d want %0d (score beat %0d)", what, got, want,
               scores_seen);
    end
  endtask

  // Each accepted score beat is checked against the oldest expectation.
  always @(posedge clk) begin
    score_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_scores.size() == 0) begin
        report_mismatch("score beat with nothing pending", out_bus.score, 0);
      end else begin
        want = pending_scores.pop_front();
        if (out_bus.class_index !== want.cls) begin
          report_mismatch("class_index", out_bus.class_index, want.cls);
        end
        if (out_bus.score !== want.score) begin
          report_mismatch("score", out_bus.score, want.score);
        end
        if (out_bus.last_class !== want.last) begin
          report_mismatch("last_class", out_bus.last_class, want.last);
        end
      end
      scores_seen++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d scores still pending", cycles,
               pending_scores.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    errors      = 0;
    cycles      = 0;
    beats_sent  = 0;
    evaluations = 0;
    scores_seen = 0;
    burst_left  = 0;
    stall_mode  = 0;
    stall_left  = 0;
    stall_tick  = 0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_INPUT_COUNT;
    cfg_data    = '0;
    in_bus.valid        = 1'b0;
    in_bus.req_type     = REQ_WEIGHT;
    in_bus.layer_select = 2'd0;
    in_bus.entry_index  = 8'd0;
    in_bus.value        = 32'sd0;
    in_bus.last_element = 1'b0;
    out_bus.ready       = 1'b0;
    cnt_in = 5'd1;
    cnt_l1 = 5'd1;
    cnt_l2 = 5'd0;
    cnt_l3 = 5'd0;
    xf_l1  = XF_LOGSIG;
    xf_l2  = XF_LOGSIG;
    xf_l3  = XF_LOGSIG;
    weight_mem = '{default: 32'sd0};
    bias_mem   = '{default: 32'sd0};
    sample_vec = '{default: 32'sd0};
    build_luts();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_preload();
    test_reset_defaults();
    test_transfer_codes();
    test_deep_network();
    test_ignored_beats();
    test_random_traffic();
    hold_off();

    $display("Covered %0d input beats, %0d evaluations and %0d score beats", beats_sent,
             evaluations, scores_seen);
    $display("over every transfer code, one to three layers and saturated counts.");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
